/* rtl/core/csa_pkg.sv */
`timescale 1ns / 1ps

package csa_pkg;

  localparam int unsigned BlockSize  = 8;
  localparam int unsigned ColW       = $clog2(BlockSize);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned LineW      = SampleW + 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_CHROMA_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MCU_COLS    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MCU_ROWS    = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_HORZ = 2'd1,
    MODE_VERT = 2'd2,
    MODE_BOTH = 2'd3
  } csa_mode_e;

  // write request into the line store
  typedef struct packed {
    logic              we;
    logic [ColW-1:0]   idx;
    logic [LineW-1:0]  data;
  } csa_line_wr_t;

  // one result item
  typedef struct packed {
    logic               last;
    logic [SampleW-1:0] value;
    logic [2:0]         col;
    logic [2:0]         row;
    logic [1:0]         blk;
  } csa_result_t;

endpackage

/* rtl/core/chroma_subsample_averager.sv */
`timescale 1ns / 1ps

// channel  | dir | tdata (low bit first)                                 | tlast
// s_axis   | in  | block_index[1:0] sample_row[2:0] sample_col[2:0]       | -
//          |     | sample_value[15:0]                                    |
// m_axis   | out | out_block[1:0] out_row[2:0] out_col[2:0]              | mcu_last
//          |     | out_value[15:0]                                       |
// cfg      | in  | cfg_we_i, cfg_idx_i (0 mode, 1 mcu_cols, 2 mcu_rows), cfg_data_i
//
// one sample is taken every clock while the skid entry is empty; its result, if any, is
// registered into the output register, or into the skid entry while m_axis stalls
// a one-entry skid register keeps s_axis_tready_o high while a result waits, so a
// stall on m_axis reaches the input only after two results are held
// reset clears the configuration registers and the output valid bits; the line store and the
// pending sample are not cleared and hold nothing meaningful until written
module chroma_subsample_averager (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [csa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [csa_pkg::CfgDataW-1:0]  cfg_data_i,
  // input samples
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [23:0]                   s_axis_tdata_i,  // block_index, sample_row,
                                                         // sample_col, sample_value
  // output results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [23:0]                   m_axis_tdata_o,  // out_block, out_row,
                                                         // out_col, out_value
  output logic                          m_axis_tlast_o   // mcu_last
);

  // configuration registers
  csa_pkg::csa_mode_e mode_q;
  logic [1:0]         mcu_cols_q;
  logic [1:0]         mcu_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= csa_pkg::MODE_NONE;
      mcu_cols_q <= 2'd1;
      mcu_rows_q <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csa_pkg::REG_CHROMA_MODE: mode_q     <= csa_pkg::csa_mode_e'(cfg_data_i);
        csa_pkg::REG_MCU_COLS:    mcu_cols_q <= cfg_data_i;
        csa_pkg::REG_MCU_ROWS:    mcu_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack the input transfer
  logic [1:0]                 in_blk;
  logic [2:0]                 in_row;
  logic [2:0]                 in_col;
  logic [csa_pkg::SampleW-1:0] in_val;

  assign in_blk = s_axis_tdata_i[1:0];
  assign in_row = s_axis_tdata_i[4:2];
  assign in_col = s_axis_tdata_i[7:5];
  assign in_val = s_axis_tdata_i[23:8];

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // size registers read 0 as 1 and 3 as 2
  logic two_cols, two_rows;
  logic [1:0] last_blk;
  assign two_cols = mcu_cols_q[1];
  assign two_rows = mcu_rows_q[1];
  assign last_blk = {two_cols & two_rows, two_cols | two_rows};

  // pending even-column sample
  logic [csa_pkg::SampleW-1:0] pend_q;
  logic                        pend_we;

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q <= in_val;
    end
  end

  // line store
  csa_pkg::csa_line_wr_t     line_wr;
  logic [csa_pkg::ColW-1:0]  line_rd_idx;
  logic [csa_pkg::LineW-1:0] line_rd;

  csa_line_store u_line (
    .clk_i     (clk_i),
    .wr_i      (line_wr),
    .rd_idx_i  (line_rd_idx),
    .rd_data_o (line_rd)
  );

  // sums, all two's complement with explicit sign extension
  logic [16:0] sum_h;      // pending + sample
  logic [16:0] sum_h_rnd;
  logic [17:0] sum_v;      // stored entry (sample or pair sum) + sample
  logic [17:0] sum_v_rnd;
  logic [17:0] sum_q;      // stored pair sum + pending + sample
  logic [17:0] sum_q_rnd;

  assign sum_h     = {pend_q[15], pend_q} + {in_val[15], in_val};
  assign sum_h_rnd = sum_h + {16'd0, sum_h[16]};
  assign sum_v     = {line_rd[16], line_rd} + {{2{in_val[15]}}, in_val};
  assign sum_v_rnd = sum_v + {17'd0, sum_v[17]};
  assign sum_q     = {line_rd[16], line_rd} + {sum_h[16], sum_h};
  // truncation toward zero: bias negative sums by divisor minus one
  assign sum_q_rnd = sum_q + {16'd0, sum_q[17], sum_q[17]};

  // per-mode decode of one transfer
  logic                 produce;
  csa_pkg::csa_result_t res;

  always_comb begin
    produce       = 1'b0;
    pend_we       = 1'b0;
    line_wr.we    = 1'b0;
    line_wr.idx   = in_col;
    line_wr.data  = {in_val[15], in_val};
    line_rd_idx   = in_col;
    res.blk       = in_blk;
    res.row       = in_row;
    res.col       = in_col;
    res.value     = in_val;
    res.last      = (in_blk == last_blk) && (in_row == 3'd7) && (in_col == 3'd7);
    case (mode_q)
      csa_pkg::MODE_NONE: begin
        produce = 1'b1;
      end
      csa_pkg::MODE_HORZ: begin
        pend_we   = !in_col[0];
        produce   = in_col[0];
        res.value = sum_h_rnd[16:1];
        res.blk   = {1'b0, in_blk[1]};
        res.col   = {in_blk[0], in_col[2:1]};
      end
      csa_pkg::MODE_VERT: begin
        line_wr.we = !in_row[0];
        produce    = in_row[0];
        res.value  = sum_v_rnd[16:1];
        if (two_cols) begin
          res.blk = {1'b0, in_blk[0]};
          res.row = {in_blk[1], in_row[2:1]};
        end else begin
          res.blk = 2'd0;
          res.row = {in_blk[0], in_row[2:1]};
        end
      end
      csa_pkg::MODE_BOTH: begin
        line_rd_idx  = {1'b0, in_col[2:1]};
        line_wr.idx  = {1'b0, in_col[2:1]};
        line_wr.data = sum_h;
        pend_we      = !in_col[0];
        line_wr.we   = in_col[0] && !in_row[0];
        produce      = in_col[0] && in_row[0];
        res.value    = sum_q_rnd[17:2];
        res.blk      = 2'd0;
        res.row      = {in_blk[1], in_row[2:1]};
        res.col      = {in_blk[0], in_col[2:1]};
      end
      default: ;
    endcase
    // state changes only on a transfer
    pend_we    = pend_we && in_fire;
    line_wr.we = line_wr.we && in_fire;
    produce    = produce && in_fire;
  end

  // output register with one skid entry behind it
  logic                 out_v_q, out_v_d;
  logic                 skid_v_q, skid_v_d;
  csa_pkg::csa_result_t out_q, out_d;
  csa_pkg::csa_result_t skid_q, skid_d;
  logic                 out_free;

  assign out_free = !out_v_q || m_axis_tready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (out_free) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = produce;
        out_d   = res;
      end
    end else if (produce) begin
      skid_v_d = 1'b1;
      skid_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready_o = !skid_v_q;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.value, out_q.col, out_q.row, out_q.blk};
  assign m_axis_tlast_o  = out_q.last;

  // the skid entry is only ever filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry valid with empty output register");

  // a held skid entry is not lost while the output stalls
  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !m_axis_tready_i) |=> skid_v_q)
    else $error("skid entry dropped during stall");

  // pass-through mode yields a result for every transfer
  a_none_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == csa_pkg::MODE_NONE && out_free) |=> out_v_q)
    else $error("pass-through transfer gave no result");

  // an even column in 4:2:0 mode only feeds the pending sample
  a_both_even_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == csa_pkg::MODE_BOTH && !in_col[0] && !out_v_q) |=> !out_v_q)
    else $error("even-column 4:2:0 transfer produced a result");

endmodule

/* rtl/core/csa_cell.sv */
`timescale 1ns / 1ps

// one entry of the line store; the read value ripples along the row
module csa_cell (
  input  logic                         clk_i,
  input  csa_pkg::csa_line_wr_t        wr_i,
  input  logic [csa_pkg::ColW-1:0]     cell_idx_i,
  input  logic [csa_pkg::ColW-1:0]     rd_idx_i,
  input  logic [csa_pkg::LineW-1:0]    rd_chain_i,
  output logic [csa_pkg::LineW-1:0]    rd_chain_o
);

  logic [csa_pkg::LineW-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.idx == cell_idx_i)) begin
      entry_q <= wr_i.data;
    end
  end

  // take over the chain when this cell is the one addressed
  assign rd_chain_o = (rd_idx_i == cell_idx_i) ? entry_q : rd_chain_i;

endmodule

/* rtl/core/csa_line_store.sv */
`timescale 1ns / 1ps

// row of cells holding one line of even-row samples or pair sums
module csa_line_store (
  input  logic                         clk_i,
  input  csa_pkg::csa_line_wr_t        wr_i,
  input  logic [csa_pkg::ColW-1:0]     rd_idx_i,
  output logic [csa_pkg::LineW-1:0]    rd_data_o
);

  logic [csa_pkg::LineW-1:0] chain [csa_pkg::BlockSize+1];

  assign chain[0] = '0;

  for (genvar k = 0; k < csa_pkg::BlockSize; k++) begin : g_cell
    csa_cell u_cell (
      .clk_i      (clk_i),
      .wr_i       (wr_i),
      .cell_idx_i (csa_pkg::ColW'(k)),
      .rd_idx_i   (rd_idx_i),
      .rd_chain_i (chain[k]),
      .rd_chain_o (chain[k+1])
    );
  end

  assign rd_data_o = chain[csa_pkg::BlockSize];

endmodule
